/* sv/sra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg
// Shared constants, types and codes of the skyline rectangle allocator.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int MAX_SIDE     = 4096;
  localparam int DIM_W        = 13;
  localparam int POS_W        = 12;
  localparam int AREA_W       = 25;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 13;

  localparam logic [STATUS_W-1:0] STATUS_PLACED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 8'd1;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [DIM_W-1:0] wid;
    logic [DIM_W-1:0] lvl;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INIT,
    S_SCAN,
    S_TRY_RD,
    S_TRY_EV,
    S_DECIDE,
    S_CP_SETUP,
    S_CP_RD,
    S_INS,
    S_CP_EV,
    S_FLUSH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic init_seg;
    logic scan_begin;
    logic try_eval;
    logic decide;
    logic cp_begin;
    logic rd_cp;
    logic ins;
    logic cp_eval;
    logic flush;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_init;
    logic size_ok;
    logic try_end;
    logic scan_last;
    logic found;
    logic full;
    logic at_insert;
    logic cp_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/sra_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_if
// Request, response and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface sra_req_if import sra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;
  modport source (output valid, rect_width, rect_height, input ready);
  modport sink (input valid, rect_width, rect_height, output ready);
endinterface

interface sra_rsp_if import sra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    place_x;
  logic [POS_W-1:0]    place_y;
  logic [AREA_W-1:0]   used_area;
  modport source (output valid, status, place_x, place_y, used_area, input ready);
  modport sink (input valid, status, place_x, place_y, used_area, output ready);
endinterface

interface sra_cfg_if import sra_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/sra_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_ctrl
// Sequencer: init, candidate scan, list rebuild and result hand-off.
// ----------------------------------------------------------------------------
module sra_ctrl import sra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (req_valid_i) state_d = S_START;
      S_START:    state_d = sts_i.need_init ? S_INIT : S_SCAN;
      S_INIT:     state_d = S_SCAN;
      S_SCAN:     state_d = sts_i.size_ok ? S_TRY_RD : S_DECIDE;
      S_TRY_RD:   state_d = S_TRY_EV;
      S_TRY_EV: begin
        if (sts_i.try_end && sts_i.scan_last) state_d = S_DECIDE;
        else state_d = S_TRY_RD;
      end
      S_DECIDE:   state_d = (sts_i.found && !sts_i.full) ? S_CP_SETUP : S_FINISH;
      S_CP_SETUP: state_d = S_CP_RD;
      S_CP_RD:    state_d = sts_i.at_insert ? S_INS : S_CP_EV;
      S_INS:      state_d = S_CP_RD;
      S_CP_EV:    state_d = sts_i.cp_last ? S_FLUSH : S_CP_RD;
      S_FLUSH:    state_d = S_FINISH;
      S_FINISH:   if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      S_INIT:     cmd_o.init_seg   = 1'b1;
      S_SCAN:     cmd_o.scan_begin = 1'b1;
      S_TRY_EV:   cmd_o.try_eval   = 1'b1;
      S_DECIDE:   cmd_o.decide     = 1'b1;
      S_CP_SETUP: cmd_o.cp_begin   = 1'b1;
      S_CP_RD:    cmd_o.rd_cp      = 1'b1;
      S_INS:      cmd_o.ins        = 1'b1;
      S_CP_EV:    cmd_o.cp_eval    = 1'b1;
      S_FLUSH:    cmd_o.flush      = 1'b1;
      S_FINISH:   cmd_o.finish     = sts_i.out_free;
      default:    cmd_o            = '0;
    endcase
  end

endmodule

/* sv/sra_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_dp
// Datapath: segment store (two banks), candidate search and list rebuild.
// ----------------------------------------------------------------------------
module sra_dp import sra_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [DIM_W-1:0]      rect_width_i,
  input  logic [DIM_W-1:0]      rect_height_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output logic [STATUS_W-1:0]   rsp_status_o,
  output logic [POS_W-1:0]      rsp_place_x_o,
  output logic [POS_W-1:0]      rsp_place_y_o,
  output logic [AREA_W-1:0]     rsp_used_area_o
);

  localparam logic [DIM_W-1:0] MaxSide = DIM_W'(MAX_SIDE);
  localparam logic [SEG_CNT_W-1:0] MaxSeg = SEG_CNT_W'(MAX_SEGMENTS);

  // Two banks: the rebuild streams the old list from one into the other.
  seg_t mem [2*MAX_SEGMENTS];
  seg_t rd_q;

  logic [DIM_W-1:0]       aw_q, ah_q, w_q, h_q;
  logic [2*DIM_W-1:0]     prod_q;
  logic [SEG_CNT_W-1:0]   count_q, ocount_q;
  logic [AREA_W-1:0]      area_q;
  logic                   bank_q;
  logic [SEG_IDX_W-1:0]   i_q, k_q, idx_q, best_i_q;
  logic                   first_q, found_q, p_valid_q, trim_q, ins_done_q;
  logic [DIM_W-1:0]       y_q, cw_q, best_w_q, by_q;
  logic signed [DIM_W+1:0] left_q;
  logic [POS_W-1:0]       cx_q, bx_q;
  logic [DIM_W:0]         best_top_q, ins_end_q;
  seg_t                   p_q;
  logic [STATUS_W-1:0]    status_q;
  logic                   rsp_valid_q;
  logic [STATUS_W-1:0]    rsp_status_q;
  logic [POS_W-1:0]       rsp_x_q, rsp_y_q;
  logic [AREA_W-1:0]      rsp_area_q;

  // Candidate evaluation of one segment under the rectangle's span.
  logic [DIM_W-1:0]        y_n, cand_w;
  logic [POS_W-1:0]        cand_x;
  logic signed [DIM_W+1:0] left_cur, left_n;
  logic [DIM_W:0]          top;
  logic                    more, rej, try_end, better;

  always_comb begin
    y_n      = (first_q || rd_q.lvl > y_q) ? rd_q.lvl : y_q;
    left_cur = first_q ? $signed({2'b00, w_q}) : left_q;
    left_n   = left_cur - $signed({2'b00, rd_q.wid});
    more     = left_n > 0;
    top      = {1'b0, y_n} + {1'b0, h_q};
    rej      = (first_q && ({2'b00, rd_q.x} + {1'b0, w_q} >= {1'b0, aw_q}))
             || (top >= {1'b0, ah_q})
             || (more && ({1'b0, k_q} + 1'b1 == count_q));
    try_end  = rej || !more;
    cand_x   = first_q ? rd_q.x : cx_q;
    cand_w   = first_q ? rd_q.wid : cw_q;
    better   = !found_q || top < best_top_q || (top == best_top_q && cand_w < best_w_q);
  end

  // Segment emitted into the new list during the rebuild.
  logic [DIM_W:0] seg_end;
  logic           emit_en, merge, trim_off;
  seg_t           emit_seg;

  always_comb begin
    seg_end  = {2'b00, rd_q.x} + {1'b0, rd_q.wid};
    emit_en  = 1'b0;
    trim_off = 1'b0;
    emit_seg = rd_q;
    if (cmd_i.ins) begin
      emit_en      = 1'b1;
      emit_seg.x   = bx_q;
      emit_seg.wid = w_q;
      emit_seg.lvl = by_q + h_q;
    end else if (cmd_i.cp_eval) begin
      if (!trim_q) begin
        emit_en = 1'b1;
      end else if ({2'b00, rd_q.x} >= ins_end_q) begin
        emit_en  = 1'b1;
        trim_off = 1'b1;
      end else if (seg_end > ins_end_q) begin
        // Partly covered: the segment now starts at the new segment's end.
        emit_en      = 1'b1;
        trim_off     = 1'b1;
        emit_seg.x   = ins_end_q[POS_W-1:0];
        emit_seg.wid = DIM_W'(seg_end - ins_end_q);
      end
    end
    merge = p_valid_q && (p_q.lvl == emit_seg.lvl);
  end

  // Memory ports.
  logic                 we;
  logic [SEG_IDX_W:0]   waddr, raddr;
  seg_t                 wdata;

  always_comb begin
    we    = 1'b0;
    waddr = {~bank_q, ocount_q[SEG_IDX_W-1:0]};
    wdata = p_q;
    if (cmd_i.init_seg) begin
      we        = 1'b1;
      waddr     = {bank_q, {SEG_IDX_W{1'b0}}};
      wdata.x   = POS_W'(1);
      wdata.wid = (aw_q >= DIM_W'(2)) ? aw_q - DIM_W'(2) : '0;
      wdata.lvl = DIM_W'(1);
    end else if (cmd_i.flush || (emit_en && p_valid_q && !merge)) begin
      we = 1'b1;
    end
    raddr = {bank_q, cmd_i.rd_cp ? idx_q : k_q};
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Configuration and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q    <= DIM_W'(512);
      ah_q    <= DIM_W'(512);
      count_q <= '0;
      area_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_ATLAS_WIDTH) begin
        aw_q <= (cfg_data_i > MaxSide) ? MaxSide : cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_ATLAS_HEIGHT) begin
        ah_q <= (cfg_data_i > MaxSide) ? MaxSide : cfg_data_i;
      end
      if (cmd_i.init_seg) begin
        count_q <= SEG_CNT_W'(1);
      end else if (cmd_i.flush) begin
        count_q <= ocount_q + 1'b1;
        bank_q  <= ~bank_q;
        area_q  <= area_q + prod_q[AREA_W-1:0];
      end
    end
  end

  // Working registers of the search and rebuild.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      first_q    <= 1'b0;
      p_valid_q  <= 1'b0;
      trim_q     <= 1'b0;
      ins_done_q <= 1'b0;
      i_q        <= '0;
      k_q        <= '0;
      idx_q      <= '0;
      ocount_q   <= '0;
      status_q   <= STATUS_NOFIT;
    end else begin
      if (cmd_i.accept) begin
        w_q <= rect_width_i;
        h_q <= rect_height_i;
      end
      if (cmd_i.scan_begin) begin
        prod_q  <= w_q * h_q;
        found_q <= 1'b0;
        i_q     <= '0;
        k_q     <= '0;
        first_q <= 1'b1;
      end
      if (cmd_i.try_eval) begin
        if (try_end) begin
          if (!rej && better) begin
            found_q    <= 1'b1;
            best_top_q <= top;
            best_w_q   <= cand_w;
            best_i_q   <= i_q;
            bx_q       <= cand_x;
            by_q       <= y_n;
          end
          i_q     <= i_q + 1'b1;
          k_q     <= i_q + 1'b1;
          first_q <= 1'b1;
        end else begin
          k_q     <= k_q + 1'b1;
          first_q <= 1'b0;
          y_q     <= y_n;
          left_q  <= left_n;
          cx_q    <= cand_x;
          cw_q    <= cand_w;
        end
      end
      if (cmd_i.decide) begin
        if (!found_q) status_q <= STATUS_NOFIT;
        else if (count_q >= MaxSeg) status_q <= STATUS_FULL;
        else status_q <= STATUS_PLACED;
      end
      if (cmd_i.cp_begin) begin
        idx_q      <= '0;
        ocount_q   <= '0;
        p_valid_q  <= 1'b0;
        trim_q     <= 1'b0;
        ins_done_q <= 1'b0;
        ins_end_q  <= {2'b00, bx_q} + {1'b0, w_q};
      end
      if (cmd_i.ins) begin
        ins_done_q <= 1'b1;
        trim_q     <= 1'b1;
      end
      if (cmd_i.cp_eval) begin
        idx_q <= idx_q + 1'b1;
        if (trim_off) trim_q <= 1'b0;
      end
      if (emit_en) begin
        if (merge) begin
          p_q.wid <= p_q.wid + emit_seg.wid;
        end else begin
          if (p_valid_q) ocount_q <= ocount_q + 1'b1;
          p_q       <= emit_seg;
          p_valid_q <= 1'b1;
        end
      end
    end
  end

  // Response register: a finished result waits here while the next request
  // may already be accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_status_q <= status_q;
      rsp_x_q      <= (status_q == STATUS_PLACED) ? bx_q : '0;
      rsp_y_q      <= (status_q == STATUS_PLACED) ? by_q[POS_W-1:0] : '0;
      rsp_area_q   <= area_q;
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_status_o    = rsp_status_q;
  assign rsp_place_x_o   = rsp_x_q;
  assign rsp_place_y_o   = rsp_y_q;
  assign rsp_used_area_o = rsp_area_q;

  assign sts_o.need_init = (count_q == '0);
  assign sts_o.size_ok   = (w_q != '0) && (h_q != '0);
  assign sts_o.try_end   = try_end;
  assign sts_o.scan_last = ({1'b0, i_q} + 1'b1 == count_q);
  assign sts_o.found     = found_q;
  assign sts_o.full      = (count_q >= MaxSeg);
  assign sts_o.at_insert = !ins_done_q && (idx_q == best_i_q);
  assign sts_o.cp_last   = ({1'b0, idx_q} + 1'b1 == count_q);
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxSeg)
    else $error("segment count above store size");

  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> bank_q != $past(bank_q))
    else $error("rebuild did not switch banks");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.try_eval |-> k_q >= i_q)
    else $error("span walk fell behind its start segment");

  a_flush_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |-> found_q && ins_done_q && p_valid_q)
    else $error("rebuild committed without a placement");

endmodule

/* sv/skyline_rect_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_rect_allocator
// Bottom-left skyline packer for a 2D atlas.
// ----------------------------------------------------------------------------
// Requests on req_i carry a rectangle size; each gives one response on rsp_o
// with a status, the placed corner and the running used area. The atlas size
// registers are written on cfg_i (index 0 width, 1 height), by the user only
// while idle, which the block itself does not enforce; cfg_i is always ready and
// values above 4096 saturate. A placed request has its response loaded
// after the list rebuild, and the next request can be accepted while that
// response is valid; a request that fails skips the rebuild. Every try
// walks the segments under the rectangle's span, reading each from the
// segment store (one read and one write port). The list rebuild (insert,
// trim, merge) streams the store once into its second bank. The very first
// request also creates the first segment. Worst case arises when many
// narrow segments lie under a wide request.
// After reset the atlas is 512 by 512 and empty; no clearing pass is needed.
// The result waits in an output register: the next request is accepted while
// it is held, and if the receiver still stalls when the following result is
// done, that request waits before its response is loaded.
// ----------------------------------------------------------------------------
module skyline_rect_allocator import sra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sra_req_if.sink   req_i,
  sra_rsp_if.source rsp_o,
  sra_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  sra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sra_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rect_width_i    (req_i.rect_width),
    .rect_height_i   (req_i.rect_height),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_status_o    (rsp_o.status),
    .rsp_place_x_o   (rsp_o.place_x),
    .rsp_place_y_o   (rsp_o.place_y),
    .rsp_used_area_o (rsp_o.used_area)
  );

endmodule
